### hdl/rct_pkg.sv
// Shared types and constants for the reader coverage table.
// Holds operation codes, sequencer states, item and table entry layouts.
// No dependencies.
package rct_pkg;

    localparam int KEY_W   = 64;
    localparam int POS_W   = 24;
    localparam int RAD_W   = 23;
    localparam int LVL_W   = 16;
    localparam int CNT_W   = 32;
    localparam int SPAN_W  = 25;
    localparam int RATIO_W = 17;
    localparam int STAT_W  = 2;
    localparam int MODE_W  = 3;

    localparam int DVD_W = 48;
    localparam int DVS_W = 33;

    localparam logic [MODE_W-1:0] MODE_SET  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DIST = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OVL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NF   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;

    typedef enum logic [2:0] {
        OP_SET, OP_ADD, OP_DIST, OP_OVL, OP_READ, OP_NOP
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_EXEC, ST_MUL, ST_NUM, ST_SQ_X, ST_SQ_Y, ST_SQ_SUM,
        ST_SQRT, ST_SQ_DONE, ST_DIV_GO, ST_DIV_WAIT, ST_WRITE, ST_OUT
    } st_t;

    typedef struct packed {
        op_t               op;
        logic [KEY_W-1:0]  key_a;
        logic [KEY_W-1:0]  key_b;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [RAD_W-1:0]  reach;
        logic [LVL_W-1:0]  sample;
    } item_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [RAD_W-1:0] radius;
        logic [LVL_W-1:0] mean;
        logic [CNT_W-1:0] count;
    } entry_t;

    localparam int ENT_W = $bits(entry_t);

endpackage

### hdl/rct_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module rct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hdl/rct_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rct_pkg for operand widths.
module rct_div
    import rct_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);
    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(DVD_W);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

### hdl/rct_front.sv
// Front end: takes items off the input stream, decodes the mode and queues them.
// Depends on rct_pkg for item_t and mode codes.
module rct_front
    import rct_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [215:0]                  s_axis_tdata,
    input  logic [7:0]                    s_axis_tuser,
    output logic                          item_valid,
    output item_t                         item,
    input  logic                          item_pop
);
    item_t      q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    logic       pop;
    item_t      dec;

    always_comb begin
        unique case (s_axis_tuser[MODE_W-1:0])
            MODE_SET:  dec.op = OP_SET;
            MODE_ADD:  dec.op = OP_ADD;
            MODE_DIST: dec.op = OP_DIST;
            MODE_OVL:  dec.op = OP_OVL;
            MODE_READ: dec.op = OP_READ;
            default:   dec.op = OP_NOP;
        endcase
        dec.key_a  = s_axis_tdata[63:0];
        dec.key_b  = s_axis_tdata[127:64];
        dec.x      = s_axis_tdata[151:128];
        dec.y      = s_axis_tdata[175:152];
        dec.reach  = s_axis_tdata[198:176];
        dec.sample = s_axis_tdata[214:199];
    end

    assign s_axis_tready = (fill_reg != 2'd2);
    assign push = s_axis_tvalid && s_axis_tready;
    assign pop  = item_pop && item_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                q_reg[wr_ptr_reg] <= dec;
                wr_ptr_reg        <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign item_valid = (fill_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];
endmodule

### hdl/rct_back.sv
// Back end: table scan, square root, divide and result register.
// Depends on rct_pkg, rct_ram and rct_div.
module rct_back
    import rct_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_valid,
    input  item_t       item,
    output logic        item_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,
    output logic [7:0]  m_axis_tuser
);
    localparam int IW  = $clog2(TABLE_DEPTH);
    localparam int SCW = IW + 1;

    st_t  state_reg, state_next;
    item_t item_reg;

    logic [SCW-1:0]         scan_cnt_reg;
    logic                   chk_vld_reg;
    logic [IW-1:0]          chk_idx_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                   a_hit_reg, b_hit_reg, free_hit_reg;
    logic [IW-1:0]          a_idx_reg, b_idx_reg, free_idx_reg;
    entry_t                 a_ent_reg, b_ent_reg, rd_ent;
    logic [ENT_W-1:0]       rd_raw;
    logic                   issue;

    logic                   wr_en;
    logic [IW-1:0]          wr_idx_reg;
    entry_t                 wr_ent_reg;

    logic signed [48:0]     prod_reg;
    logic signed [49:0]     num;
    logic                   neg_reg;
    logic [DVD_W-1:0]       dvd_reg;
    logic [DVS_W-1:0]       dvs_reg;
    logic                   div_start, div_done;
    logic [DVD_W-1:0]       quo;
    logic [LVL_W-1:0]       mean_new;

    logic signed [24:0]     dx, dy;
    logic [48:0]            dxx_reg, dyy_reg;
    logic [23:0]            sum;
    logic [47:0]            sum2_reg;
    logic [49:0]            d2_reg;
    logic [49:0]            sq_src_reg;
    logic [27:0]            sq_rem_reg;
    logic [SPAN_W-1:0]      sq_root_reg;
    logic [4:0]             sq_cnt_reg;
    logic [27:0]            rem_sh, trial;
    logic                   sq_fit;
    logic                   ovl_hit;

    logic [STAT_W-1:0]      res_status_reg;
    logic [SPAN_W-1:0]      res_span_reg;
    logic [RATIO_W-1:0]     res_ratio_reg;
    logic [LVL_W-1:0]       res_mean_reg;
    logic                   m_valid_reg;
    logic                   out_free;

    assign issue  = scan_cnt_reg < SCW'(TABLE_DEPTH);
    assign rd_ent = entry_t'(rd_raw);
    assign wr_en  = (state_reg == ST_WRITE);

    rct_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_idx_reg),
        .wdata (wr_ent_reg),
        .raddr (scan_cnt_reg[IW-1:0]),
        .rdata (rd_raw)
    );

    rct_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .done     (div_done),
        .quotient (quo)
    );

    // geometry
    assign dx  = $signed({a_ent_reg.x[POS_W-1], a_ent_reg.x})
               - $signed({b_ent_reg.x[POS_W-1], b_ent_reg.x});
    assign dy  = $signed({a_ent_reg.y[POS_W-1], a_ent_reg.y})
               - $signed({b_ent_reg.y[POS_W-1], b_ent_reg.y});
    assign sum = {1'b0, a_ent_reg.radius} + {1'b0, b_ent_reg.radius};
    assign ovl_hit = (sum != '0) && (d2_reg < {2'b00, sum2_reg});

    // one root bit per cycle, two radicand bits consumed
    assign rem_sh = {sq_rem_reg[25:0], sq_src_reg[49:48]};
    assign trial  = {1'b0, sq_root_reg, 2'b01};
    assign sq_fit = rem_sh >= trial;

    assign num      = 50'(prod_reg) + 50'($signed(item_reg.sample));
    assign mean_new = neg_reg ? LVL_W'(-quo[LVL_W-1:0]) : quo[LVL_W-1:0];
    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        item_pop   = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    item_pop   = 1'b1;
                    state_next = (item.op == OP_NOP) ? ST_OUT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!issue && !chk_vld_reg) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                unique case (item_reg.op)
                    OP_SET:  state_next = (a_hit_reg || free_hit_reg) ? ST_WRITE : ST_OUT;
                    OP_ADD:  state_next = a_hit_reg ? ST_MUL : ST_OUT;
                    OP_DIST,
                    OP_OVL:  state_next = (a_hit_reg && b_hit_reg) ? ST_SQ_X : ST_OUT;
                    default: state_next = ST_OUT;
                endcase
            end
            ST_MUL:    state_next = ST_NUM;
            ST_NUM:    state_next = ST_DIV_GO;
            ST_SQ_X:   state_next = ST_SQ_Y;
            ST_SQ_Y:   state_next = ST_SQ_SUM;
            ST_SQ_SUM: state_next = ST_SQRT;
            ST_SQRT: begin
                if (sq_cnt_reg == 5'd1) state_next = ST_SQ_DONE;
            end
            ST_SQ_DONE: begin
                state_next = (item_reg.op == OP_OVL && ovl_hit) ? ST_DIV_GO : ST_OUT;
            end
            ST_DIV_GO: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) state_next = (item_reg.op == OP_ADD) ? ST_WRITE : ST_OUT;
            end
            ST_WRITE: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
            chk_vld_reg  <= 1'b0;
            scan_cnt_reg <= '0;
        end else begin
            // result register: load a new result or drop the one taken
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (item_valid) begin
                        item_reg       <= item;
                        scan_cnt_reg   <= '0;
                        chk_vld_reg    <= 1'b0;
                        a_hit_reg      <= 1'b0;
                        b_hit_reg      <= 1'b0;
                        free_hit_reg   <= 1'b0;
                        res_status_reg <= STAT_OK;
                        res_span_reg   <= '0;
                        res_ratio_reg  <= '0;
                        res_mean_reg   <= '0;
                    end
                end
                ST_SCAN: begin
                    chk_vld_reg <= issue;
                    chk_idx_reg <= scan_cnt_reg[IW-1:0];
                    if (issue) scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    if (chk_vld_reg) begin
                        if (valid_reg[chk_idx_reg]) begin
                            if (!a_hit_reg && rd_ent.key == item_reg.key_a) begin
                                a_hit_reg <= 1'b1;
                                a_idx_reg <= chk_idx_reg;
                                a_ent_reg <= rd_ent;
                            end
                            if (!b_hit_reg && rd_ent.key == item_reg.key_b) begin
                                b_hit_reg <= 1'b1;
                                b_idx_reg <= chk_idx_reg;
                                b_ent_reg <= rd_ent;
                            end
                        end else if (!free_hit_reg) begin
                            free_hit_reg <= 1'b1;
                            free_idx_reg <= chk_idx_reg;
                        end
                    end
                end
                ST_EXEC: begin
                    unique case (item_reg.op)
                        OP_SET: begin
                            wr_idx_reg <= a_hit_reg ? a_idx_reg : free_idx_reg;
                            wr_ent_reg <= '{key: item_reg.key_a, x: item_reg.x,
                                            y: item_reg.y, radius: item_reg.reach,
                                            mean: '0, count: '0};
                            if (!a_hit_reg && !free_hit_reg) res_status_reg <= STAT_FULL;
                        end
                        OP_ADD: begin
                            wr_idx_reg <= a_idx_reg;
                            wr_ent_reg <= a_ent_reg;
                            if (!a_hit_reg) res_status_reg <= STAT_NF;
                        end
                        OP_DIST, OP_OVL: begin
                            if (!(a_hit_reg && b_hit_reg)) res_status_reg <= STAT_NF;
                        end
                        OP_READ: begin
                            if (a_hit_reg) res_mean_reg <= a_ent_reg.mean;
                            else           res_status_reg <= STAT_NF;
                        end
                        default: ;
                    endcase
                end
                ST_MUL: begin
                    prod_reg <= $signed(a_ent_reg.mean) * $signed({1'b0, a_ent_reg.count});
                end
                ST_NUM: begin
                    neg_reg <= num[49];
                    dvd_reg <= num[49] ? DVD_W'(-num) : num[DVD_W-1:0];
                    dvs_reg <= {1'b0, a_ent_reg.count} + 1'b1;
                end
                ST_SQ_X: dxx_reg <= 49'(dx * dx);
                ST_SQ_Y: begin
                    dyy_reg  <= 49'(dy * dy);
                    sum2_reg <= sum * sum;
                end
                ST_SQ_SUM: begin
                    d2_reg      <= {1'b0, dxx_reg} + {1'b0, dyy_reg};
                    sq_src_reg  <= {1'b0, dxx_reg} + {1'b0, dyy_reg};
                    sq_rem_reg  <= '0;
                    sq_root_reg <= '0;
                    sq_cnt_reg  <= 5'(SPAN_W);
                end
                ST_SQRT: begin
                    sq_rem_reg  <= sq_fit ? rem_sh - trial : rem_sh;
                    sq_root_reg <= {sq_root_reg[SPAN_W-2:0], sq_fit};
                    sq_src_reg  <= {sq_src_reg[47:0], 2'b00};
                    sq_cnt_reg  <= sq_cnt_reg - 1'b1;
                end
                ST_SQ_DONE: begin
                    res_span_reg <= sq_root_reg;
                    dvd_reg      <= {7'b0, sq_root_reg, 16'b0};
                    dvs_reg      <= {9'b0, sum};
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        if (item_reg.op == OP_ADD) begin
                            wr_ent_reg.mean  <= mean_new;
                            wr_ent_reg.count <= (&wr_ent_reg.count) ? wr_ent_reg.count
                                                : wr_ent_reg.count + 1'b1;
                        end else begin
                            res_ratio_reg <= RATIO_ONE - quo[RATIO_W-1:0];
                        end
                    end
                end
                ST_WRITE: valid_reg[wr_idx_reg] <= 1'b1;
                ST_OUT: begin
                    if (out_free) begin
                        m_axis_tuser <= {6'b0, res_status_reg};
                        m_axis_tdata <= {6'b0, res_mean_reg, res_ratio_reg, res_span_reg};
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside its wait state");

    a_valid_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> $countones(valid_reg) >= $past($countones(valid_reg)))
        else $error("table entry lost its valid bit");

    a_root_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SQ_DONE |->
            (52'(sq_root_reg) * 52'(sq_root_reg)) <= 52'(d2_reg))
        else $error("square root above radicand");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        item_pop |=> state_reg == ST_SCAN || state_reg == ST_OUT)
        else $error("item taken without starting work");
endmodule

### hdl/reader_coverage_table.sv
// Reader coverage table, top level.
// Depends on rct_pkg, rct_front and rct_back (which holds rct_ram and rct_div).
//
// A keyed table of up to TABLE_DEPTH readers. Each item carries a mode in
// tuser: set position, add signal sample, pair distance, pair overlap, read
// mean; other modes return an all-zero result. Every item gives exactly one
// result item, in order. Items are handled one at a time by the back end;
// the front queue holds two more items and the result register lets the next
// item start while a result is still waiting on m_axis. Steps per item: the
// item is taken, then every lookup scans the whole table, one entry a cycle
// from the table RAM. Then set position and read mean finish; distance adds
// the squares of the offsets and of the radius sum and a square root;
// overlap adds a restoring divide when the circles intersect; add sample
// runs a multiply/add, the same divide and the write back.
// Status in tuser: 0 ok, 1 reader not found, 2 table full.
module reader_coverage_table
    import rct_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [63:0] first_reader, [127:64] second_reader, [151:128] pos_x,
    // [175:152] pos_y, [198:176] reach, [214:199] sample
    input  logic [215:0] s_axis_tdata,
    // [2:0] mode
    input  logic [7:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [24:0] span, [41:25] overlap_ratio, [57:42] mean_level
    output logic [63:0]  m_axis_tdata,
    // [1:0] status
    output logic [7:0]   m_axis_tuser
);
    logic  item_valid;
    logic  item_pop;
    item_t item;

    // accept and decode, two-item queue
    rct_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop)
    );

    // table, arithmetic and result register
    rct_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );
endmodule
